### rtl/core/gcr_pkg.sv
// ----------------------------------------------------------------------------
// gcr_pkg
// Types and constants shared by the ground contact resolver files.
// ----------------------------------------------------------------------------
package gcr_pkg;

  localparam int WordW    = 32;
  localparam int FracW    = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 31;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_SLOP    = 2'd0,
    REG_RESTIT  = 2'd1,
    REG_STATIC  = 2'd2,
    REG_DYNAMIC = 2'd3
  } reg_idx_t;

  // area floor of 0.0001 in Q16.16, and 2^32/pi rounded
  localparam logic [30:0] AreaFloor = 31'd7;
  localparam logic [31:0] InvPiQ32  = 32'd1367130551;

  // ceil(2^34/5): multiply then shift by 34 gives floor(x/5) for 32-bit x
  localparam logic [31:0] Div5Recip = 32'hCCCC_CCCD;

  typedef struct packed {
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] spin_x;
    logic signed [31:0] spin_y;
    logic signed [31:0] spin_z;
    logic [30:0]        area;
    logic [30:0]        step_time;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic signed [31:0] new_spin_x;
    logic signed [31:0] new_spin_y;
    logic signed [31:0] new_spin_z;
    logic               in_contact;
  } out_word_t;

  // magnitude times unsigned Q16.16 factor, truncated toward zero, saturated
  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                              input logic [31:0] b);
    logic        neg;
    logic [31:0] mag;
    logic [63:0] p;
    logic [47:0] q;
    logic signed [31:0] r;
    begin
      neg = a[31];
      mag = neg ? (32'd0 - a) : a;
      p   = {32'd0, mag} * {32'd0, b};
      q   = p[63:16];
      if (neg) begin
        if (q >= 48'h8000_0000) r = 32'sh8000_0000;
        else r = -$signed(q[31:0]);
      end else begin
        if (q >= 48'h8000_0000) r = 32'sh7fff_ffff;
        else r = $signed(q[31:0]);
      end
      mulq = r;
    end
  endfunction

  // non-negative magnitude times unsigned Q16.16 factor, saturated positive
  function automatic logic signed [31:0] mulq_mag(input logic [31:0] mag,
                                                  input logic [31:0] b);
    logic [63:0] p;
    logic [47:0] q;
    begin
      p = {32'd0, mag} * {32'd0, b};
      q = p[63:16];
      if (q >= 48'h8000_0000) mulq_mag = 32'sh7fff_ffff;
      else mulq_mag = $signed(q[31:0]);
    end
  endfunction

endpackage

### rtl/core/gcr_stream_if.sv
// ----------------------------------------------------------------------------
// gcr_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface gcr_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/ground_contact_resolver.sv
// ----------------------------------------------------------------------------
// ground_contact_resolver
// Ground-plane contact for one rigid body per word, fully pipelined.
// ----------------------------------------------------------------------------
// channel   dir  payload
// in_ch     in   gcr_pkg::in_word_t  (body state, area, step time)
// out_ch    out  gcr_pkg::out_word_t (corrected state, contact flag)
// cfg_*     in   plain write port, four registers
//
// one word per cycle while out_ch does not stall; an area product stage, a radius
// root over 32 stages, two square stages, a speed root over 33 stages, then
// damping and output stages.
// rst is synchronous and clears only the valid bits and the registers.
// a stall on out_ch freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ground_contact_resolver (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gcr_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [gcr_pkg::CfgDataW-1:0]  cfg_data,
  gcr_stream_if.sink                    in_ch,
  gcr_stream_if.source                  out_ch
);
  import gcr_pkg::*;

  localparam int TagW = $bits(in_word_t);

  logic [30:0] slop_tol;
  logic [16:0] restitution;
  logic [30:0] grip_thr;
  logic [30:0] drag_coef;

  // friction threshold, a fifth of the static coefficient
  logic [63:0] thr_prod;
  logic [30:0] grip_thr_next;
  assign thr_prod      = {33'd0, cfg_data} * {32'd0, Div5Recip};
  assign grip_thr_next = {1'b0, thr_prod[63:34]};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slop_tol    <= '0;
      restitution <= '0;
      grip_thr    <= '0;
      drag_coef   <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_SLOP:    slop_tol    <= cfg_data;
        REG_RESTIT:  restitution <= cfg_data[16:0];
        REG_STATIC:  grip_thr    <= grip_thr_next;
        REG_DYNAMIC: drag_coef   <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advances whenever the output slot is free or taken
  logic en;
  logic ovalid;
  assign en          = !ovalid || out_ch.ready;
  assign in_ch.ready = en;

  // stage a: area/pi product
  logic        a_v;
  in_word_t    a_d;
  logic [63:0] a_x;
  logic [30:0] area_fl;
  assign area_fl = (in_ch.data.area < AreaFloor) ? AreaFloor : in_ch.data.area;
  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (en) a_v <= in_ch.valid;
    if (en) begin
      a_d <= in_ch.data;
      a_x <= ({33'd0, area_fl} * {32'd0, InvPiQ32}) >> (32 - FracW);
    end
  end

  // radius root
  logic        r_v;
  logic [31:0] r_root;
  in_word_t    r_d;
  gcr_isqrt #(.IN_W(64), .TAG_W(TagW)) u_rad (
    .clk, .rst, .en, .in_valid(a_v), .x(a_x), .tag_in(a_d),
    .out_valid(r_v), .root(r_root), .tag_out(r_d)
  );

  // stage b: contact test, square of the x speed and friction product
  typedef struct packed {
    in_word_t    d;
    logic [31:0] radius;
    logic        contact;
    logic [47:0] prod;
  } b_t;
  logic        b_v;
  b_t          b_d;
  logic [63:0] b_sq;
  logic signed [33:0] pen;
  logic [31:0] ax;
  assign pen = $signed({2'b0, r_root}) - 34'(r_d.pos_y);
  assign ax  = r_d.vel_x[31] ? 32'd0 - r_d.vel_x : r_d.vel_x;
  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (en) b_v <= r_v;
    if (en) begin
      b_d.d       <= r_d;
      b_d.radius  <= r_root;
      b_d.contact <= pen > $signed({3'b0, slop_tol});
      b_d.prod    <= 48'(({31'd0, drag_coef} * {31'd0, r_d.step_time}) >> FracW);
      b_sq        <= 64'({32'd0, ax} * {32'd0, ax});
    end
  end

  // stage c: sum of squares
  logic        c_v;
  b_t          c_d;
  logic [64:0] c_x;
  logic [63:0] azz;
  logic [31:0] bz;
  assign bz  = b_d.d.vel_z[31] ? 32'd0 - b_d.d.vel_z : b_d.d.vel_z;
  assign azz = {32'd0, bz} * {32'd0, bz};
  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (en) c_v <= b_v;
    if (en) begin
      c_d <= b_d;
      c_x <= {1'b0, b_sq} + {1'b0, azz};
    end
  end

  // horizontal speed root
  logic [65:0] c_x2;
  logic        h_v;
  logic [32:0] h_root;
  b_t          h_d;
  assign c_x2 = {1'b0, c_x};
  gcr_isqrt #(.IN_W(66), .TAG_W($bits(b_t))) u_spd (
    .clk, .rst, .en, .in_valid(c_v), .x(c_x2), .tag_in(c_d),
    .out_valid(h_v), .root(h_root), .tag_out(h_d)
  );

  // stage e: damping factors and decisions
  logic        e_v;
  b_t          e_d;
  logic [31:0] e_dl, e_ds;
  logic        e_stop, e_move;
  logic [49:0] sub4, sub2;
  assign sub4 = {h_d.prod, 2'b00};
  assign sub2 = {1'b0, h_d.prod, 1'b0};
  always_ff @(posedge clk) begin
    if (rst) e_v <= 1'b0;
    else if (en) e_v <= h_v;
    if (en) begin
      e_d    <= h_d;
      e_dl   <= (sub4 >= 50'h10000) ? 32'd0 : 32'(50'h10000 - sub4);
      e_ds   <= (sub2 >= 50'h10000) ? 32'd0 : 32'(50'h10000 - sub2);
      e_move <= h_root != 33'd0;
      e_stop <= h_root < {2'b0, grip_thr};
    end
  end

  // stage f: multiplies and result select
  out_word_t f_d, o_d;
  logic [31:0] vy_mag;
  assign vy_mag = 32'd0 - e_d.d.vel_y;
  always_comb begin
    f_d.new_pos_y  = e_d.d.pos_y;
    f_d.new_vel_x  = e_d.d.vel_x;
    f_d.new_vel_y  = e_d.d.vel_y;
    f_d.new_vel_z  = e_d.d.vel_z;
    f_d.new_spin_x = e_d.d.spin_x;
    f_d.new_spin_y = e_d.d.spin_y;
    f_d.new_spin_z = e_d.d.spin_z;
    f_d.in_contact = e_d.contact;
    if (e_d.contact) begin
      f_d.new_pos_y = e_d.radius[31] ? 32'sh7fff_ffff : $signed(e_d.radius);
      if (e_d.d.vel_y[31]) f_d.new_vel_y = mulq_mag(vy_mag, {15'd0, restitution});
      if (e_move) begin
        if (e_stop) begin
          f_d.new_vel_x = '0;
          f_d.new_vel_z = '0;
        end else begin
          f_d.new_vel_x = mulq(e_d.d.vel_x, e_dl);
          f_d.new_vel_z = mulq(e_d.d.vel_z, e_dl);
        end
      end
      f_d.new_spin_x = mulq(e_d.d.spin_x, e_ds);
      f_d.new_spin_y = mulq(e_d.d.spin_y, e_ds);
      f_d.new_spin_z = mulq(e_d.d.spin_z, e_ds);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) ovalid <= 1'b0;
    else if (en) ovalid <= e_v;
    if (en) o_d <= f_d;
  end

  assign out_ch.valid = ovalid;
  assign out_ch.data  = o_d;
endmodule

### rtl/core/gcr_isqrt.sv
// ----------------------------------------------------------------------------
// gcr_isqrt
// Pipelined integer square root, one result bit per stage, stall aware.
// ----------------------------------------------------------------------------
module gcr_isqrt #(
  parameter int IN_W  = 64,
  parameter int TAG_W = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [IN_W-1:0]       x,
  input  logic [TAG_W-1:0]      tag_in,
  output logic                  out_valid,
  output logic [IN_W/2-1:0]     root,
  output logic [TAG_W-1:0]      tag_out
);
  localparam int N = IN_W / 2;

  logic [IN_W-1:0]  rem  [0:N];
  logic [N-1:0]     res  [0:N];
  logic [TAG_W-1:0] tag  [0:N];
  logic             vld  [0:N];

  assign rem[0] = x;
  assign res[0] = '0;
  assign tag[0] = tag_in;
  assign vld[0] = in_valid;

  // one digit per stage, restoring method
  for (genvar i = 0; i < N; i++) begin : g_st
    logic [IN_W-1:0] trial;
    logic [IN_W-1:0] rem_next;
    logic [N-1:0]    res_next;
    always_comb begin
      trial = {{(IN_W-N){1'b0}}, res[i]} << (N - i);
      trial = trial | ({{(IN_W-1){1'b0}}, 1'b1} << (2*(N-1-i)));
      if (rem[i] >= trial) begin
        rem_next = rem[i] - trial;
        res_next = res[i] | ({{(N-1){1'b0}}, 1'b1} << (N-1-i));
      end else begin
        rem_next = rem[i];
        res_next = res[i];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        rem[i+1] <= rem_next;
        res[i+1] <= res_next;
        tag[i+1] <= tag[i];
      end
    end
  end

  assign out_valid = vld[N];
  assign root      = res[N];
  assign tag_out   = tag[N];
endmodule

### dv/ground_contact_resolver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ground_contact_resolver_tb
// Streams rigid bodies through the contact resolver under several friction, slop
// and restitution settings. Every result word is checked against a hand-written
// value or an in-bench fixed-point predictor, with both channels idling and stalling.
// ----------------------------------------------------------------------------
module ground_contact_resolver_tb;
  import gcr_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 400;
  localparam longint SMAX = 64'sd2147483647;

  typedef struct {
    in_word_t  body;
    bit        typed;
    out_word_t want;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  gcr_stream_if #(.payload_t(in_word_t))  in_ch ();
  gcr_stream_if #(.payload_t(out_word_t)) out_ch ();

  ground_contact_resolver uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // predictor copy of the registers
  longint unsigned slop_q, restit_q, static_q, dynamic_q;

  out_word_t   expected_q[$];
  stim_row_t   stim_tab[$];
  int          mismatches = 0;
  int          words_sent = 0;
  int          words_checked = 0;
  int          contacts_seen = 0;
  int          cycles = 0;
  int          burst_left = 0;
  int          gap_max = 0;
  int          stall_pct = 0;
  int          hold_left = 0;
  int          hold_reqs = 0;
  int          holds_done = 0;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 30) $display("[%0t] %s", $realtime, msg);
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // signed value times unsigned Q16.16 factor, truncated toward zero, saturated
  function automatic logic signed [31:0] scale_q(input longint a, input longint unsigned b);
    longint unsigned mag;
    longint unsigned p;
    longint r;
    mag = (a < 0) ? longint'(-a) : longint'(a);
    p   = (mag * b) >> FracW;
    if (a < 0) begin
      if (p > 64'd2147483648) p = 64'd2147483648;
      r = -longint'(p);
    end else begin
      r = (p > 64'd2147483647) ? SMAX : longint'(p);
    end
    return r[31:0];
  endfunction

  function automatic longint unsigned damping(input longint unsigned prod,
                                              input longint unsigned k);
    longint unsigned sub;
    sub = prod * k;
    return (sub >= 64'd65536) ? 64'd0 : 64'd65536 - sub;
  endfunction

  // expected resolved body for one input word under the current registers
  function automatic out_word_t resolve_contact(input in_word_t b);
    out_word_t r;
    longint unsigned area, radius, ax, az, speed, prod, d;
    longint pen, vx, vy, vz;
    area = b.area;
    if (area < AreaFloor) area = AreaFloor;
    radius = int_sqrt((area * longint'(InvPiQ32)) >> (32 - FracW));
    pen = longint'(radius) - longint'(b.pos_y);
    r.new_pos_y  = b.pos_y;
    r.new_vel_x  = b.vel_x;
    r.new_vel_y  = b.vel_y;
    r.new_vel_z  = b.vel_z;
    r.new_spin_x = b.spin_x;
    r.new_spin_y = b.spin_y;
    r.new_spin_z = b.spin_z;
    r.in_contact = 1'b0;
    if (pen > longint'(slop_q)) begin
      r.in_contact = 1'b1;
      r.new_pos_y = (longint'(radius) > SMAX) ? SMAX[31:0] : radius[31:0];
      vx = b.vel_x;
      vy = b.vel_y;
      vz = b.vel_z;
      if (vy < 0) r.new_vel_y = scale_q(-vy, restit_q);
      ax = (vx < 0) ? -vx : vx;
      az = (vz < 0) ? -vz : vz;
      speed = int_sqrt(ax * ax + az * az);
      prod  = (dynamic_q * longint'(b.step_time)) >> FracW;
      if (speed > 0) begin
        if (speed < static_q / 5) begin
          r.new_vel_x = '0;
          r.new_vel_z = '0;
        end else begin
          d = damping(prod, 4);
          r.new_vel_x = scale_q(vx, d);
          r.new_vel_z = scale_q(vz, d);
        end
      end
      d = damping(prod, 2);
      r.new_spin_x = scale_q(b.spin_x, d);
      r.new_spin_y = scale_q(b.spin_y, d);
      r.new_spin_z = scale_q(b.spin_z, d);
    end
    return r;
  endfunction

  function automatic in_word_t body(input int py, input int vx, input int vy, input int vz,
                                    input int sx, input int sy, input int sz,
                                    input int ar, input int dt);
    in_word_t b;
    b.pos_y = py;  b.vel_x = vx;  b.vel_y = vy;  b.vel_z = vz;
    b.spin_x = sx; b.spin_y = sy; b.spin_z = sz;
    b.area = ar[30:0]; b.step_time = dt[30:0];
    return b;
  endfunction

  function automatic int rand_vel();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return 0;
      default: return $urandom_range(0, 1 << 20) - (1 << 19);
    endcase
  endfunction

  function automatic in_word_t random_body();
    in_word_t b;
    int ar, dt;
    b = body(0, rand_vel(), rand_vel(), rand_vel(), rand_vel(), rand_vel(), rand_vel(), 0, 1);
    b.pos_y = ($urandom_range(9) < 4) ? $urandom : $urandom_range(0, 200000) - 100000;
    case ($urandom_range(9))
      0:          ar = $urandom_range(0, 10);
      1, 2, 3:    ar = $urandom & 32'h7fff_ffff;
      default:    ar = $urandom_range(0, 200000);
    endcase
    dt = ($urandom_range(9) < 7) ? $urandom_range(1, 8192) : $urandom_range(1, 32'h7fff_ffff);
    b.area = ar[30:0];
    b.step_time = dt[30:0];
    return b;
  endfunction

  // one register write, predictor copy follows
  task automatic write_reg(input reg_idx_t idx, input longint unsigned val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val[CfgDataW-1:0];
    @(posedge clk);
    case (idx)
      REG_SLOP:    slop_q    = val & 64'h7fff_ffff;
      REG_RESTIT:  restit_q  = val & 64'h1_ffff;
      REG_STATIC:  static_q  = val & 64'h7fff_ffff;
      REG_DYNAMIC: dynamic_q = val & 64'h7fff_ffff;
      default: ;
    endcase
  endtask

  task automatic write_all(input longint unsigned s, input longint unsigned r,
                           input longint unsigned sf, input longint unsigned df);
    write_reg(REG_SLOP, s);
    write_reg(REG_RESTIT, r);
    write_reg(REG_STATIC, sf);
    write_reg(REG_DYNAMIC, df);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every outstanding word, then let the pipe settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic offer(input in_word_t b, input bit typed, input out_word_t want);
    if (burst_left == 0 && gap_max > 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= b;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(typed ? want : resolve_contact(b));
    words_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report($sformatf("%s got %h want %h", name, got, want));
  endtask

  // receiver: check each accepted word and stall on its own pattern
  always @(posedge clk) begin
    out_word_t w, e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      w = out_ch.data;
      if (expected_q.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        e = expected_q.pop_front();
        words_checked++;
        if (w.in_contact === 1'b1) contacts_seen++;
        check_field("new_pos_y", w.new_pos_y, e.new_pos_y);
        check_field("new_vel_x", w.new_vel_x, e.new_vel_x);
        check_field("new_vel_y", w.new_vel_y, e.new_vel_y);
        check_field("new_vel_z", w.new_vel_z, e.new_vel_z);
        check_field("new_spin_x", w.new_spin_x, e.new_spin_x);
        check_field("new_spin_y", w.new_spin_y, e.new_spin_y);
        check_field("new_spin_z", w.new_spin_z, e.new_spin_z);
        check_field("in_contact", {31'd0, w.in_contact}, {31'd0, e.in_contact});
      end
    end
    if (hold_reqs != holds_done) begin
      holds_done = hold_reqs;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // stimulus
  initial begin
    out_word_t want;
    in_word_t  b;
    int        n;
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_idx      <= REG_SLOP;
    cfg_data     <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    slop_q = 0; restit_q = 0; static_q = 0; dynamic_q = 0;

    // body well above the ground passes untouched
    b = body(32'h7fff_ffff, 0, 0, 0, 0, 0, 0, 0, 1);
    want = '{b.pos_y, b.vel_x, b.vel_y, b.vel_z, b.spin_x, b.spin_y, b.spin_z, 1'b0};
    stim_tab.push_back('{b, 1'b1, want});
    // deep below ground, floored area: radius 382, fall stopped, zero damping
    b = body(32'h8000_0000, 5 << 16, -3 << 16, -2 << 16, 1, -1, 32'h8000_0000, 0,
             32'h7fff_ffff);
    want = '{32'sd382, b.vel_x, 32'sd0, b.vel_z, b.spin_x, b.spin_y, b.spin_z, 1'b1};
    stim_tab.push_back('{b, 1'b1, want});
    // rising body in contact keeps its vertical speed
    b = body(-1000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
             32'h8000_0000, 7, 6, 1);
    want = '{32'sd382, b.vel_x, b.vel_y, b.vel_z, b.spin_x, b.spin_y, b.spin_z, 1'b1};
    stim_tab.push_back('{b, 1'b1, want});
    stim_tab.push_back('{body(0, 0, 0, 0, 0, 0, 0, 0, 1), 1'b0, want});
    stim_tab.push_back('{body(382, 1, -1, 1, 1, 1, 1, 7, 1), 1'b0, want});
    stim_tab.push_back('{body(381, 1, -1, 1, 1, 1, 1, 7, 1), 1'b0, want});
    stim_tab.push_back('{body(0, -1, -1, -1, -1, -1, -1, 8, 3), 1'b0, want});
    stim_tab.push_back('{body(0, 0, 0, 0, 0, 0, 0, 32'h7fff_ffff, 1), 1'b0, want});
    stim_tab.push_back('{body(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                              32'h8000_0000, 32'h7fff_ffff, -1, 32'h7fff_ffff,
                              32'h7fff_ffff), 1'b0, want});
    stim_tab.push_back('{body(100, 3 << 16, 0, 4 << 16, 5, -5, 0, 65536, 655), 1'b0, want});
    stim_tab.push_back('{body(-5, 10, -(10 << 16), -10, 9, 9, 9, 65536, 65536), 1'b0, want});
    stim_tab.push_back('{body(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                              32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 31'h2aaa_aaaa,
                              31'h5555_5555), 1'b0, want});
    stim_tab.push_back('{body(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                              32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 31'h5555_5555,
                              31'h2aaa_aaaa), 1'b0, want});

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int phase = 0; phase < 7; phase++) begin
      // register settings: reset values, extremes, unit bounce, unit friction, then random
      case (phase)
        0: ;
        1: write_all(64'h7fff_ffff, 64'h1_ffff, 64'h7fff_ffff, 64'h7fff_ffff);
        2: write_all(0, 65536, 0, 0);
        3: write_all(0, 0, 5 << 16, 65536);
        default: write_all($urandom_range(0, 1 << 17), $urandom_range(0, 32'h1_ffff),
                           $urandom_range(0, 1 << 22),
                           $urandom_range(0, 1 << $urandom_range(4, 20)));
      endcase
      gap_max   = (phase == 2) ? 0 : ((phase % 2) ? 6 : 3);
      stall_pct = (phase == 2) ? 0 : 10 * phase;
      burst_left = 0;

      foreach (stim_tab[i])
        offer(stim_tab[i].body, stim_tab[i].typed && phase == 0, stim_tab[i].want);

      // long receiver hold while words keep coming
      if (phase == 2) hold_reqs++;
      n = 250;
      for (int k = 0; k < n; k++) begin
        if (k == n / 2 && phase != 2) begin
          in_ch.valid <= 1'b0;
          while (expected_q.size() != 0) @(posedge clk);
        end
        offer(random_body(), 1'b0, want);
      end
      drain();
    end

    $display("sent %0d bodies over 7 register settings, checked %0d results", words_sent,
             words_checked);
    $display("%0d results were in contact, including a long output stall", contacts_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
